### hw/rtl/pem_pkg.sv
// Shared types and constants for the Prewitt edge magnitude block.
package pem_pkg;

  // Channel payload widths.
  localparam int PIX_W      = 8;
  localparam int MAG_W      = 8;
  localparam int POS_W      = 11;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 12;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

  // Register reset values and the smallest usable frame dimension.
  localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RST  = 12'd640;
  localparam logic [CFG_DATA_W-1:0] IMAGE_HEIGHT_RST = 12'd480;
  localparam int MIN_DIM = 3;

  // Gray conversion: sum / 3 as (sum * 683) >> 11, exact for sums up to 765.
  localparam int GRAY_W     = 8;
  localparam int RGB_SUM_W  = 10;
  localparam logic [RGB_SUM_W-1:0] GRAY_MUL = 10'd683;
  localparam int GRAY_SHIFT = 11;

  // Gradient and magnitude arithmetic.
  localparam int SUM_W      = 11;  // signed, covers -765..765
  localparam int SQ_W       = 21;  // sumx^2 + sumy^2 stays below 2^21
  localparam int RT_W       = 17;
  localparam int ROOT_STEPS = 8;
  localparam int ROOT_TOP   = 1 << 14;
  localparam logic [MAG_W-1:0] MAG_MAX = 8'hFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // latch gray value, start line store read
    logic win;       // shift window, write line store, form gradients
    logic square;    // form the squared sum, seed the root
    logic root;      // one step of the square root
    logic out_load;  // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_result;  // current pixel completes a full window
    logic out_free;    // output register can take a result this cycle
  } sts_t;

endpackage

### hw/rtl/pem_if.sv
// Handshake interfaces for the pixel, result and configuration channels.
interface pem_pix_if;
  logic                    valid;
  logic                    ready;
  logic [pem_pkg::PIX_W-1:0] red;
  logic [pem_pkg::PIX_W-1:0] green;
  logic [pem_pkg::PIX_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface pem_res_if;
  logic                      valid;
  logic                      ready;
  logic [pem_pkg::MAG_W-1:0] magnitude;
  logic [pem_pkg::POS_W-1:0] out_row;
  logic [pem_pkg::POS_W-1:0] out_col;
  logic                      frame_last;

  modport source (output valid, output magnitude, output out_row, output out_col,
                  output frame_last, input ready);
  modport sink   (input valid, input magnitude, input out_row, input out_col,
                  input frame_last, output ready);
endinterface

interface pem_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pem_pkg::CFG_IDX_W-1:0]  index;
  logic [pem_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/pem_ctrl.sv
// Controller state machine that sequences one pixel through the datapath.
module pem_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pix_valid_i,
  output logic          pix_ready_o,
  input  pem_pkg::sts_t sts_i,
  output pem_pkg::cmd_t cmd_o
);
  import pem_pkg::*;

  localparam int CNT_W = $clog2(ROOT_STEPS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WIN  = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_ROOT = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // Next state and command decode.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    pix_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        pix_ready_o = 1'b1;
        if (pix_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_WIN;
        end
      end
      S_WIN: begin
        cmd_o.win = 1'b1;
        state_d   = sts_i.has_result ? S_SQ : S_IDLE;
      end
      S_SQ: begin
        cmd_o.square = 1'b1;
        cnt_d        = '0;
        state_d      = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.root = 1'b1;
        cnt_d      = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(ROOT_STEPS - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and step counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // A window step always follows an accepted request.
  a_win_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WIN) |-> $past(pix_valid_i && pix_ready_o))
    else $error("window step without an accepted pixel");

  // Squaring happens only for pixels that complete a full window.
  a_sq_needs_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQ) |-> $past(state_q == S_WIN && sts_i.has_result))
    else $error("squaring started on a border pixel");

  // The root leaves only after its full number of steps.
  a_root_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && $past(state_q == S_ROOT)) |->
      ($past(cnt_q) == CNT_W'(ROOT_STEPS - 1)))
    else $error("square root ended early");

endmodule

### hw/rtl/pem_dpath.sv
// Datapath: gray conversion, line store, window, gradients, square root, output.
module pem_dpath #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [pem_pkg::PIX_W-1:0] red_i,
  input  logic [pem_pkg::PIX_W-1:0] green_i,
  input  logic [pem_pkg::PIX_W-1:0] blue_i,
  input  pem_pkg::cmd_t             cmd_i,
  output pem_pkg::sts_t             sts_o,
  pem_cfg_if.sink                   cfg,
  pem_res_if.source                 res
);
  import pem_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int DWW  = $clog2(MAX_WIDTH + 1);
  localparam int DHW  = $clog2(MAX_HEIGHT + 1);
  localparam int CMPW = (DWW > CFG_DATA_W) ? DWW : CFG_DATA_W;
  localparam int CMPH = (DHW > CFG_DATA_W) ? DHW : CFG_DATA_W;
  localparam int PWC  = (CW > POS_W) ? CW : POS_W;
  localparam int PWR  = (RW > POS_W) ? RW : POS_W;

  // Configuration registers and position counters.
  logic [CFG_DATA_W-1:0] width_q, height_q;
  logic [CW-1:0]         c_q, cur_c_q;
  logic [RW-1:0]         r_q, cur_r_q;

  // Pixel, line store and window state.
  logic [GRAY_W-1:0]     gray_q;
  logic [2*GRAY_W-1:0]   ls_mem [MAX_WIDTH];
  logic [2*GRAY_W-1:0]   rd_q;
  logic [GRAY_W-1:0]     win_q [3][3];  // [column][row], row 0 on top

  // Gradients and root.
  logic signed [SUM_W-1:0] sumx_q, sumy_q;
  logic [RT_W-1:0]         v_q, res_q, bit_q;
  logic                    sat_q;

  // Per-item tags and the output register.
  logic [POS_W-1:0] pos_row_q, pos_col_q, o_row_q, o_col_q;
  logic             last_q, o_last_q, ov_q;
  logic [MAG_W-1:0] o_mag_q;

  // Effective frame dimensions, clamped to the usable range.
  logic [DWW-1:0]  w_eff;
  logic [DHW-1:0]  h_eff;
  logic [CMPW-1:0] wext;
  logic [CMPH-1:0] hext;

  always_comb begin
    wext = CMPW'(width_q);
    hext = CMPH'(height_q);
    if (wext < CMPW'(MIN_DIM)) begin
      w_eff = DWW'(MIN_DIM);
    end else if (wext > CMPW'(MAX_WIDTH)) begin
      w_eff = DWW'(MAX_WIDTH);
    end else begin
      w_eff = wext[DWW-1:0];
    end
    if (hext < CMPH'(MIN_DIM)) begin
      h_eff = DHW'(MIN_DIM);
    end else if (hext > CMPH'(MAX_HEIGHT)) begin
      h_eff = DHW'(MAX_HEIGHT);
    end else begin
      h_eff = hext[DHW-1:0];
    end
  end

  // Gray value of the incoming pixel.
  logic [RGB_SUM_W-1:0]   rgb_sum;
  logic [2*RGB_SUM_W-1:0] gray_prod;

  always_comb begin
    rgb_sum   = RGB_SUM_W'(red_i) + RGB_SUM_W'(green_i) + RGB_SUM_W'(blue_i);
    gray_prod = (2*RGB_SUM_W)'(rgb_sum) * (2*RGB_SUM_W)'(GRAY_MUL);
  end

  // Gradients over the window after it takes the new column.
  logic [GRAY_W-1:0]    top_px, mid_px;
  logic [RGB_SUM_W-1:0] new_col, old_col, bot_row, top_row;
  logic signed [SUM_W-1:0] sumx_d, sumy_d;

  always_comb begin
    top_px  = rd_q[2*GRAY_W-1:GRAY_W];
    mid_px  = rd_q[GRAY_W-1:0];
    new_col = RGB_SUM_W'(top_px) + RGB_SUM_W'(mid_px) + RGB_SUM_W'(gray_q);
    old_col = RGB_SUM_W'(win_q[1][0]) + RGB_SUM_W'(win_q[1][1]) + RGB_SUM_W'(win_q[1][2]);
    bot_row = RGB_SUM_W'(win_q[1][2]) + RGB_SUM_W'(win_q[2][2]) + RGB_SUM_W'(gray_q);
    top_row = RGB_SUM_W'(win_q[1][0]) + RGB_SUM_W'(win_q[2][0]) + RGB_SUM_W'(top_px);
    sumx_d  = $signed({1'b0, new_col}) - $signed({1'b0, old_col});
    sumy_d  = $signed({1'b0, bot_row}) - $signed({1'b0, top_row});
  end

  // Squared magnitude.
  logic signed [2*SUM_W-1:0] sx2, sy2;
  logic [SQ_W-1:0]           sq;

  always_comb begin
    sx2 = sumx_q * sumx_q;
    sy2 = sumy_q * sumy_q;
    sq  = sx2[SQ_W-1:0] + sy2[SQ_W-1:0];
  end

  // Position bookkeeping for the current pixel.
  logic           c_last, r_last, frame_end;
  logic [PWC-1:0] col_off;
  logic [PWR-1:0] row_off;

  always_comb begin
    c_last    = (DWW'(cur_c_q) == w_eff - DWW'(1));
    r_last    = (DHW'(cur_r_q) == h_eff - DHW'(1));
    frame_end = c_last && r_last;
    col_off   = PWC'(cur_c_q) - PWC'(2);
    row_off   = PWR'(cur_r_q) - PWR'(2);
  end

  // One root step.
  logic [RT_W-1:0] trial;
  assign trial = res_q + bit_q;

  // Writes that hit a listed register.
  logic cfg_w_hit, cfg_h_hit;
  assign cfg_w_hit = cfg.valid && (cfg.index == REG_IMAGE_WIDTH);
  assign cfg_h_hit = cfg.valid && (cfg.index == REG_IMAGE_HEIGHT);

  // Status to the controller.
  always_comb begin
    sts_o.has_result = (cur_r_q >= RW'(2)) && (cur_c_q >= CW'(2));
    sts_o.out_free   = !ov_q || res.ready;
  end

  // Line store: read at request time, write back during the window step.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rd_q <= ls_mem[c_q];
    end
    if (cmd_i.win) begin
      ls_mem[cur_c_q] <= {mid_px, gray_q};
    end
  end

  // Control registers: configuration, counters, window and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= IMAGE_WIDTH_RST;
      height_q <= IMAGE_HEIGHT_RST;
      c_q      <= '0;
      r_q      <= '0;
      ov_q     <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else begin
      if (cmd_i.win) begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
        win_q[2][0] <= top_px;
        win_q[2][1] <= mid_px;
        win_q[2][2] <= gray_q;
      end
      // A write to a listed register restarts the frame.
      if (cfg_w_hit || cfg_h_hit) begin
        c_q <= '0;
        r_q <= '0;
      end else if (cmd_i.win) begin
        if (c_last) begin
          c_q <= '0;
          r_q <= r_last ? '0 : cur_r_q + RW'(1);
        end else begin
          c_q <= cur_c_q + CW'(1);
        end
      end
      if (cfg_w_hit) begin
        width_q <= cfg.data;
      end
      if (cfg_h_hit) begin
        height_q <= cfg.data;
      end
      if (cmd_i.out_load) begin
        ov_q <= 1'b1;
      end else if (res.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Payload registers along the arithmetic path.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      gray_q  <= gray_prod[GRAY_SHIFT+GRAY_W-1:GRAY_SHIFT];
      cur_c_q <= c_q;
      cur_r_q <= r_q;
    end
    if (cmd_i.win) begin
      sumx_q    <= sumx_d;
      sumy_q    <= sumy_d;
      pos_col_q <= col_off[POS_W-1:0];
      pos_row_q <= row_off[POS_W-1:0];
      last_q    <= frame_end;
    end
    if (cmd_i.square) begin
      v_q   <= {1'b0, sq[15:0]};
      sat_q <= |sq[SQ_W-1:16];
      res_q <= '0;
      bit_q <= RT_W'(ROOT_TOP);
    end
    if (cmd_i.root) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.out_load) begin
      o_mag_q  <= sat_q ? MAG_MAX : res_q[MAG_W-1:0];
      o_row_q  <= pos_row_q;
      o_col_q  <= pos_col_q;
      o_last_q <= last_q;
    end
  end

  // Channel outputs.
  assign cfg.ready      = 1'b1;
  assign res.valid      = ov_q;
  assign res.magnitude  = o_mag_q;
  assign res.out_row    = o_row_q;
  assign res.out_col    = o_col_q;
  assign res.frame_last = o_last_q;

endmodule

### hw/rtl/prewitt_edge_magnitude_top.sv
// Top level of the Prewitt edge magnitude block.
//
//   Channel  Direction  Payload                                  Handshake
//   pix      in         red, green, blue                         valid/ready
//   res      out        magnitude, out_row, out_col, frame_last  valid/ready
//   cfg      in         index, data                              valid/ready
//
// A full-window pixel passes through the request with its line store read, a window step,
// a squaring step, eight square root steps and the output load; a border pixel takes only
// the request and the window step. A waiting result stays in the output register while
// the next pixel is taken; the next full-window result stalls until that register frees.
// Reset is async, active low; cfg is always ready; width or height writes restart the frame.
module prewitt_edge_magnitude_top #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pem_pix_if.sink   pix,
  pem_res_if.source res,
  pem_cfg_if.sink   cfg
);
  import pem_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic pix_ready;

  assign pix.ready = pix_ready;

  pem_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pix.valid),
    .pix_ready_o (pix_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pem_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dpath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .red_i   (pix.red),
    .green_i (pix.green),
    .blue_i  (pix.blue),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .cfg     (cfg),
    .res     (res)
  );

endmodule

### tb/tb_prewitt_edge_magnitude_top.sv
// Self-checking testbench for the Prewitt edge magnitude block: directed frames, then random streams.
module tb_prewitt_edge_magnitude_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pem_pkg::*;

  localparam int FRAME_MAX_W  = 2048;
  localparam int FRAME_MAX_H  = 2048;
  // Border pixels may still be in flight when the last result has come.
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 420;
  localparam int RESET_ITEMS  = 24;
  localparam int LARGE_ITEMS  = 48;

  // Indexes from REG_COUNT up hit no register.
  localparam logic [CFG_IDX_W-1:0]  REG_COUNT     = 4'd2;
  localparam logic [CFG_IDX_W-1:0]  REG_INDEX_TOP = '1;
  localparam logic [CFG_DATA_W-1:0] DIM_TOP       = '1;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             frame_last;
  } mag_res_t;

  typedef enum logic {STEP_PIX, STEP_CFG} step_kind_e;
  typedef enum int {FILL_UNIFORM, FILL_EXTREME, FILL_FLAT} fill_e;

  typedef struct packed {
    step_kind_e            kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    pix_t                  px;
    logic                  typed;
    mag_res_t              want;
  } step_t;

  // Directed frames. Frame one: two black rows over a white row, which saturates.
  // Frame two: black, dark and light columns, with an unmapped register write
  // in the middle that must not restart the frame. Frame three: restarted by a
  // height write after two pixels.
  step_t dir_tab [33] = '{
    '{STEP_CFG, REG_IMAGE_WIDTH, 12'd2, '0, 1'b0, '0},
    '{STEP_CFG, REG_IMAGE_HEIGHT, 12'd0, '0, 1'b0, '0},
    '{STEP_PIX, '0, '0, '{8'd0, 8'd0, 8'd0}, 1'b0, '0},
    '{STEP_PIX, '0, '0, '{8'd1, 8'd1, 8'd0}, 1'b0, '0},
    '{STEP_PIX, '0, '0, '{8'd0, 8'd0, 8'd2}, 1'b0, '0},
    '{STEP_PIX, '0, '0, '{8'd0, 8'd0, 8'd0}, 1'b0, '0},
    '{STEP_PIX, '0, '0, '{8'd2, 8'd0, 8'd0}, 1'b0, '0},
    '{STEP_PIX, '0, '0, '{8'd0, 8'd1, 8'd1}, 1'b0, '0},
    '{STEP_PIX, '0, '0, '{8'd255, 8'd255, 8'd255}, 1'b0, '0},
    '{STEP_PIX, '0, '0, '{8'd255, 8'd255, 8'd255}, 1'b0, '0},
    '{STEP_PIX, '0, '0, '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd255, 11'd0, 11'd0, 1'b1}},
    '{STEP_PIX, '0, '0, '{8'd0, 8'd0, 8'd0}, 1'b0, '0},
    '{STEP_PIX, '0, '0, '{8'd9, 8'd9, 8'd9}, 1'b0, '0},
    '{STEP_PIX, '0, '0, '{8'd20, 8'd20, 8'd20}, 1'b0, '0},
    '{STEP_CFG, REG_INDEX_TOP, DIM_TOP, '0, 1'b0, '0},
    '{STEP_PIX, '0, '0, '{8'd0, 8'd0, 8'd0}, 1'b0, '0},
    '{STEP_PIX, '0, '0, '{8'd9, 8'd9, 8'd9}, 1'b0, '0},
    '{STEP_PIX, '0, '0, '{8'd20, 8'd20, 8'd20}, 1'b0, '0},
    '{STEP_PIX, '0, '0, '{8'd0, 8'd0, 8'd0}, 1'b0, '0},
    '{STEP_PIX, '0, '0, '{8'd9, 8'd9, 8'd9}, 1'b0, '0},
    '{STEP_PIX, '0, '0, '{8'd20, 8'd20, 8'd20}, 1'b1, '{8'd60, 11'd0, 11'd0, 1'b1}},
    '{STEP_PIX, '0, '0, '{8'd17, 8'd200, 8'd33}, 1'b0, '0},
    '{STEP_PIX, '0, '0, '{8'd255, 8'd0, 8'd0}, 1'b0, '0},
    '{STEP_CFG, REG_IMAGE_HEIGHT, 12'd1, '0, 1'b0, '0},
    '{STEP_PIX, '0, '0, '{8'd0, 8'd255, 8'd0}, 1'b0, '0},
    '{STEP_PIX, '0, '0, '{8'd0, 8'd0, 8'd255}, 1'b0, '0},
    '{STEP_PIX, '0, '0, '{8'd255, 8'd0, 8'd0}, 1'b0, '0},
    '{STEP_PIX, '0, '0, '{8'd37, 8'd90, 8'd140}, 1'b0, '0},
    '{STEP_PIX, '0, '0, '{8'd200, 8'd13, 8'd77}, 1'b0, '0},
    '{STEP_PIX, '0, '0, '{8'd64, 8'd64, 8'd64}, 1'b0, '0},
    '{STEP_PIX, '0, '0, '{8'd255, 8'd255, 8'd0}, 1'b0, '0},
    '{STEP_PIX, '0, '0, '{8'd3, 8'd250, 8'd129}, 1'b0, '0},
    '{STEP_PIX, '0, '0, '{8'd90, 8'd90, 8'd91}, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  pem_pix_if pix_ch ();
  pem_res_if res_ch ();
  pem_cfg_if cfg_ch ();

  prewitt_edge_magnitude_top #(
    .MAX_WIDTH (FRAME_MAX_W),
    .MAX_HEIGHT(FRAME_MAX_H)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix   (pix_ch),
    .res   (res_ch),
    .cfg   (cfg_ch)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the block: registers, two previous gray rows, the window and the scan position.
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;
  logic [PIX_W-1:0]      line_two_up [FRAME_MAX_W];
  logic [PIX_W-1:0]      line_one_up [FRAME_MAX_W];
  logic [PIX_W-1:0]      win_px [9];
  int unsigned           col_pos;
  int unsigned           row_pos;

  mag_res_t    mag_expect_q [$];
  int unsigned mismatch_cnt = 0;
  bit          pix_idle_on;
  bit          res_idle_on;

  // Frame dimension in use: register value held to MIN_DIM..dim_max.
  function automatic int unsigned usable_dim(input logic [CFG_DATA_W-1:0] v,
                                             input int unsigned dim_max);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > dim_max) return dim_max;
    return 32'(v);
  endfunction

  // Advances the shadow by one pixel; returns 1 when a full window yields a magnitude.
  function automatic bit predict_pixel(input pix_t px, output mag_res_t pred);
    int unsigned      w, h, c, r, gray, sq, root;
    logic [PIX_W-1:0] top_px, mid_px;
    int               sumx, sumy;
    bit               hit;
    w = usable_dim(width_reg, FRAME_MAX_W);
    h = usable_dim(height_reg, FRAME_MAX_H);
    c = (col_pos >= w) ? 0 : col_pos;
    r = (row_pos >= h) ? 0 : row_pos;
    gray = (32'(px.red) + 32'(px.green) + 32'(px.blue)) / 3;

    // Line stores shift down one row at this column.
    top_px = line_two_up[c];
    mid_px = line_one_up[c];
    line_two_up[c] = mid_px;
    line_one_up[c] = gray[PIX_W-1:0];

    // Window shifts left; the new column comes in on the right.
    for (int k = 0; k < 3; k++) begin
      win_px[3*k]   = win_px[3*k+1];
      win_px[3*k+1] = win_px[3*k+2];
    end
    win_px[2] = top_px;
    win_px[5] = mid_px;
    win_px[8] = gray[PIX_W-1:0];

    hit = (r >= 2) && (c >= 2);
    pred = '0;
    if (hit) begin
      sumx = 0;
      for (int k = 0; k < 3; k++) begin
        sumx += int'(win_px[3*k+2]) - int'(win_px[3*k]);
      end
      sumy = int'(win_px[6]) + int'(win_px[7]) + int'(win_px[8])
           - int'(win_px[0]) - int'(win_px[1]) - int'(win_px[2]);
      sq = sumx * sumx + sumy * sumy;
      // Floor square root built bit by bit, saturated above 255.
      if (sq >= 65536) begin
        root = 255;
      end else begin
        root = 0;
        for (int b = 7; b >= 0; b--) begin
          if ((root | (1 << b)) * (root | (1 << b)) <= sq) root = root | (1 << b);
        end
      end
      pred.magnitude  = root[MAG_W-1:0];
      pred.out_row    = POS_W'(r - 2);
      pred.out_col    = POS_W'(c - 2);
      pred.frame_last = (r == h - 1) && (c == w - 1);
    end

    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
    return hit;
  endfunction

  function automatic pix_t rand_pixel(input fill_e fill);
    pix_t px;
    case (fill)
      FILL_EXTREME: begin
        px.red   = $urandom_range(0, 1) ? '1 : '0;
        px.green = $urandom_range(0, 1) ? '1 : '0;
        px.blue  = $urandom_range(0, 1) ? '1 : '0;
      end
      // Nearly flat image: small gradients, no saturation.
      FILL_FLAT: begin
        px.red   = PIX_W'($urandom_range(96, 110));
        px.green = PIX_W'($urandom_range(96, 110));
        px.blue  = PIX_W'($urandom_range(96, 110));
      end
      default: begin
        px.red   = PIX_W'($urandom_range(0, 255));
        px.green = PIX_W'($urandom_range(0, 255));
        px.blue  = PIX_W'($urandom_range(0, 255));
      end
    endcase
    return px;
  endfunction

  // Mostly small frames, sometimes below the minimum or a little larger.
  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    case ($urandom_range(0, 7))
      0: return CFG_DATA_W'($urandom_range(0, MIN_DIM - 1));
      1: return CFG_DATA_W'($urandom_range(9, 12));
      default: return CFG_DATA_W'($urandom_range(MIN_DIM, 8));
    endcase
  endfunction

  // One pixel request; the expected result is queued once the request is taken.
  task automatic send_pixel(input pix_t px, input bit typed, input mag_res_t want);
    mag_res_t pred;
    bit       hit;
    if (pix_idle_on && $urandom_range(0, 3) == 0) begin
      pix_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.red   <= px.red;
    pix_ch.green <= px.green;
    pix_ch.blue  <= px.blue;
    do @(posedge clk_i); while (!pix_ch.ready);
    hit = predict_pixel(px, pred);
    if (typed) begin
      mag_expect_q.push_back(want);
    end else if (hit) begin
      mag_expect_q.push_back(pred);
    end
  endtask

  task automatic send_pixels(input int unsigned n, input fill_e fill);
    repeat (n) send_pixel(rand_pixel(fill), 1'b0, '0);
  endtask

  // Register write, issued only once the block has drained.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    pix_ch.valid <= 1'b0;
    while (mag_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) begin
      width_reg = val;
    end else if (idx == REG_IMAGE_HEIGHT) begin
      height_reg = val;
    end
    if (idx < REG_COUNT) begin
      col_pos = 0;
      row_pos = 0;
    end
  endtask

  // Result side: check each taken result, then choose the next ready value.
  initial begin
    mag_res_t    got;
    mag_res_t    want;
    int unsigned stall_left;
    stall_left   = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        got.magnitude  = res_ch.magnitude;
        got.out_row    = res_ch.out_row;
        got.out_col    = res_ch.out_col;
        got.frame_last = res_ch.frame_last;
        if (mag_expect_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("unexpected result: mag %0d row %0d col %0d last %0b",
                     got.magnitude, got.out_row, got.out_col, got.frame_last);
          end
        end else begin
          want = mag_expect_q.pop_front();
          if (got.magnitude !== want.magnitude || got.out_row !== want.out_row ||
              got.out_col !== want.out_col || got.frame_last !== want.frame_last) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("mismatch: want %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                       want.magnitude, want.out_row, want.out_col, want.frame_last,
                       got.magnitude, got.out_row, got.out_col, got.frame_last);
            end
          end
        end
      end
      if (!res_idle_on) begin
        res_ch.ready <= 1'b1;
      end else if (stall_left != 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 7) == 0) begin
        res_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 16);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned w, h, n, sent;
    fill_e       fill;
    rst_ni       = 1'b0;
    pix_ch.valid = 1'b0;
    pix_ch.red   = '0;
    pix_ch.green = '0;
    pix_ch.blue  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    width_reg    = IMAGE_WIDTH_RST;
    height_reg   = IMAGE_HEIGHT_RST;
    col_pos      = 0;
    row_pos      = 0;
    foreach (win_px[k]) win_px[k] = '0;
    pix_idle_on  = 1'b1;
    res_idle_on  = 1'b1;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset frame size: the first pixels stay in the top row and give no result.
    send_pixels(RESET_ITEMS, FILL_UNIFORM);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == STEP_CFG) begin
        write_reg(dir_tab[i].index, dir_tab[i].data);
      end else begin
        send_pixel(dir_tab[i].px, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    // Random phases: new frame sizes, unmapped writes, whole and partial frames.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pix_idle_on = ($urandom_range(0, 3) != 0);
      res_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 5) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, REG_INDEX_TOP)),
                  CFG_DATA_W'($urandom));
      end
      if ($urandom_range(0, 3) != 0) write_reg(REG_IMAGE_WIDTH, pick_dim());
      if ($urandom_range(0, 3) != 0) write_reg(REG_IMAGE_HEIGHT, pick_dim());
      w = usable_dim(width_reg, FRAME_MAX_W);
      h = usable_dim(height_reg, FRAME_MAX_H);
      n = $urandom_range(1, 2) * w * h + $urandom_range(0, w * h - 1);
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      fill = fill_e'($urandom_range(0, 2));
      send_pixels(n, fill);
      sent += n;
    end

    // Oversized registers: width held to the maximum along the top row, then
    // height held to the maximum under a run of three-wide rows.
    pix_idle_on = 1'b1;
    res_idle_on = 1'b1;
    write_reg(REG_IMAGE_WIDTH, DIM_TOP);
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(MIN_DIM));
    send_pixels(LARGE_ITEMS, FILL_UNIFORM);
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(MIN_DIM));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(FRAME_MAX_H + 1));
    send_pixels(LARGE_ITEMS, FILL_FLAT);

    // Closing stretch at full rate on both sides.
    pix_idle_on = 1'b0;
    res_idle_on = 1'b0;
    write_reg(REG_IMAGE_WIDTH, 12'd5);
    write_reg(REG_IMAGE_HEIGHT, 12'd4);
    send_pixels(40, FILL_UNIFORM);

    pix_ch.valid <= 1'b0;
    while (mag_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
